### rtl/bht_pkg.sv
// Shared types and constants for the bucketed hash table.
// Used by the channel interfaces and by every module of the block but bht_mem.
package bht_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VALUE_W = 32;

   // Action codes carried by the request word.
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_ACCESS = 2'd3
   } action_type;

   // One slot of a bucket row as it sits in the table memory.
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   // Result word fields.
   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               status;
   } result_type;

endpackage

### rtl/bht_ifs.sv
// Valid/ready channel interfaces for the bucketed hash table.
// Depends on bht_pkg for the payload types.
interface bht_req_if;
   import bht_pkg::*;
   logic                valid;
   logic                ready;
   action_type          action;
   logic [KEY_W-1:0]    key;
   logic [VALUE_W-1:0]  value;
   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

interface bht_rsp_if;
   import bht_pkg::*;
   logic                valid;
   logic                ready;
   logic                found;
   logic [VALUE_W-1:0]  read_value;
   logic                status;
   modport source (output valid, found, read_value, status, input ready);
   modport sink   (input valid, found, read_value, status, output ready);
endinterface

interface bht_csr_if;
   import bht_pkg::*;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  default_value;
   modport source (output valid, default_value, input ready);
   modport sink   (input valid, default_value, output ready);
endinterface

### rtl/bucketed_hash_table.sv
// Top level of the bucketed hash table: control, result register, config.
// Depends on bht_pkg, the channel interfaces, bht_hash, bht_mem and bht_update.
//
//   Channel  Role   Word contents
//   req_ch   sink   action, key, value
//   rsp_ch   source found, read_value, status
//   csr_ch   sink   default_value (always ready)
//
// When NUM_BUCKETS is a power of two the row read is issued as the word is
// accepted, and ST_MATCH compares and writes back. Otherwise the modulo
// unit first forms the index (reciprocal multiply, then multiply and
// subtract), and the row read is issued when it is done.
// After reset a clearing pass writes every row with req_ch.ready low. The
// result register lets a new word enter while the last result waits; the
// compare stage holds until that register is free.
module bucketed_hash_table #(
   parameter int unsigned NUM_BUCKETS      = 256,
   parameter int unsigned SLOTS_PER_BUCKET = 4
) (
   input  logic      clock,
   input  logic      reset,
   bht_req_if.sink   req_ch,
   bht_rsp_if.source rsp_ch,
   bht_csr_if.sink   csr_ch
);
   import bht_pkg::*;

   localparam int unsigned BW    = $clog2(NUM_BUCKETS);
   localparam int unsigned ROW_W = SLOTS_PER_BUCKET * $bits(slot_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MATCH
   } state_type;

   state_type          state_ff, state_in;
   logic [BW-1:0]      clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;
   logic [VALUE_W-1:0] default_value_ff, default_value_in;

   action_type         action_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [BW-1:0]      bucket_ff;

   logic               req_fire;
   logic               out_free;
   logic               match_fire;
   logic               hash_done;
   logic [BW-1:0]      hash_bucket;

   logic               wr_en;
   logic [BW-1:0]      wr_addr;
   logic [ROW_W-1:0]   wr_data;
   logic [ROW_W-1:0]   rd_data;

   slot_type [SLOTS_PER_BUCKET-1:0] row_new;
   result_type                      result;

   // Handshakes.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign match_fire   = (state_ff == ST_MATCH) && out_free;

   bht_hash #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .key    (req_ch.key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // Write port: clearing pass or write-back of the updated row.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = match_fire;
         wr_addr = bucket_ff;
         wr_data = row_new;
      end
   end

   bht_mem #(
      .DATA_W (ROW_W),
      .DEPTH  (NUM_BUCKETS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (hash_done),
      .rd_addr (hash_bucket),
      .rd_data (rd_data)
   );

   bht_update #(
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
   ) u_update (
      .row_in        (rd_data),
      .action        (action_ff),
      .key           (key_ff),
      .value         (value_ff),
      .default_value (default_value_ff),
      .row_out       (row_new),
      .result        (result)
   );

   // Next-state and registered output logic.
   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in      = rsp_data_ff;
      default_value_in = default_value_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         default_value_in = csr_ch.default_value;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = hash_done ? ST_MATCH : ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         default_value_ff <= '0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         rsp_valid_ff     <= rsp_valid_in;
         default_value_ff <= default_value_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Request word and bucket index held for the compare stage.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_ch.action;
         key_ff    <= req_ch.key;
         value_ff  <= req_ch.value;
      end
      if (hash_done) begin
         bucket_ff <= hash_bucket;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_data_ff.found;
   assign rsp_ch.read_value = rsp_data_ff.read_value;
   assign rsp_ch.status     = rsp_data_ff.status;

endmodule

### rtl/bht_hash.sv
// Bucket index unit: key modulo the bucket count.
// Depends on bht_pkg. A power-of-two count is a mask; otherwise a reciprocal multiply.
module bht_hash #(
   parameter int unsigned NUM_BUCKETS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bht_pkg::KEY_W-1:0]         key,
   output logic                              done,
   output logic [$clog2(NUM_BUCKETS)-1:0]    bucket
);
   import bht_pkg::*;

   localparam int unsigned BW = $clog2(NUM_BUCKETS);

   generate
      if ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0) begin : g_mask
         // Power-of-two bucket count: the low key bits are the index.
         assign done   = start;
         assign bucket = key[BW-1:0];
      end else begin : g_recip
         // The quotient is the key times the rounded-up reciprocal of the
         // bucket count, shifted down by KEY_W + BW. With BW = ceil(log2 N)
         // this is exact for every 32-bit key, and the reciprocal fits in
         // KEY_W + 1 bits.
         localparam int unsigned     SHIFT   = KEY_W + BW;
         localparam int unsigned     PROD_W  = 2 * KEY_W + 1;
         localparam longint unsigned RECIP   =
            ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

         logic [KEY_W-1:0]  key_ff;
         logic [PROD_W-1:0] prod_ff;
         logic [KEY_W-1:0]  qn_ff;
         logic              v1_ff;
         logic              v2_ff;
         logic [KEY_W-1:0]  quot;
         logic [KEY_W-1:0]  rem;

         // Two pipeline steps: the reciprocal product, then quotient times count.
         always_ff @(posedge clock) begin
            if (reset) begin
               v1_ff <= 1'b0;
               v2_ff <= 1'b0;
            end else begin
               v1_ff <= start;
               v2_ff <= v1_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               key_ff  <= key;
               prod_ff <= PROD_W'(key) * PROD_W'(RECIP);
            end
            if (v1_ff) begin
               qn_ff <= quot * KEY_W'(NUM_BUCKETS);
            end
         end

         // The remainder is the key less quotient times count.
         assign quot   = KEY_W'(prod_ff >> SHIFT);
         assign rem    = key_ff - qn_ff;
         assign done   = v2_ff;
         assign bucket = rem[BW-1:0];
      end
   endgenerate

endmodule

### rtl/bht_mem.sv
// Bucket row memory: one write port, one read port, registered read data.
// No package dependency.
module bht_mem #(
   parameter int unsigned DATA_W = 260,
   parameter int unsigned DEPTH  = 256
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bht_update.sv
// Slot match and row update for one bucket: compares all slots in parallel,
// builds the row to write back and the result word. Depends on bht_pkg.
module bht_update #(
   parameter int unsigned SLOTS_PER_BUCKET = 4
) (
   input  bht_pkg::slot_type [SLOTS_PER_BUCKET-1:0] row_in,
   input  bht_pkg::action_type                      action,
   input  logic [bht_pkg::KEY_W-1:0]                key,
   input  logic [bht_pkg::VALUE_W-1:0]              value,
   input  logic [bht_pkg::VALUE_W-1:0]              default_value,
   output bht_pkg::slot_type [SLOTS_PER_BUCKET-1:0] row_out,
   output bht_pkg::result_type                      result
);
   import bht_pkg::*;

   logic [SLOTS_PER_BUCKET-1:0] match_first;
   logic [SLOTS_PER_BUCKET-1:0] free_first;
   logic                        hit;
   logic                        full;
   logic [VALUE_W-1:0]          hit_value;

   // Lowest matching slot and lowest free slot, both one-hot.
   always_comb begin
      logic seen_m;
      logic seen_f;
      seen_m    = 1'b0;
      seen_f    = 1'b0;
      hit_value = '0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         match_first[s] = row_in[s].valid && (row_in[s].key == key) && !seen_m;
         free_first[s]  = !row_in[s].valid && !seen_f;
         if (match_first[s]) begin
            hit_value = row_in[s].value;
         end
         seen_m = seen_m || match_first[s];
         seen_f = seen_f || free_first[s];
      end
      hit  = seen_m;
      full = !seen_f;
   end

   // Apply the action to the row and form the result word.
   always_comb begin
      row_out           = row_in;
      result.found      = hit;
      result.read_value = '0;
      result.status     = 1'b0;
      unique case (action)
         ACT_INSERT: begin
            for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
               if (hit && match_first[s]) begin
                  row_out[s].value = value;
               end else if (!hit && free_first[s]) begin
                  row_out[s] = '{valid: 1'b1, key: key, value: value};
               end
            end
            result.status = !hit && full;
         end
         ACT_REMOVE: begin
            for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
               if (match_first[s]) begin
                  row_out[s].valid = 1'b0;
               end
            end
         end
         ACT_FIND: begin
            result.read_value = hit ? hit_value : '0;
         end
         ACT_ACCESS: begin
            result.read_value = hit ? hit_value : default_value;
            for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
               if (!hit && free_first[s]) begin
                  row_out[s] = '{valid: 1'b1, key: key, value: default_value};
               end
            end
            result.status = !hit && full;
         end
      endcase
   end

endmodule
